FILE: rtl/core/vgdf_pkg.sv
// ----------------------------------------------------------------------------
// vgdf_pkg
// shared widths, constants and types of the voxel grid duplicate filter
// ----------------------------------------------------------------------------
package vgdf_pkg;

    localparam int COORD_W     = 24;
    localparam int RES_W       = 23;
    localparam int NUM_W       = COORD_W + 1;
    localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

    // set depth must be a power of two: the home slot is the low hash bits
    localparam int SET_DEPTH   = 4096;
    localparam int ADDR_W      = $clog2(SET_DEPTH);
    localparam int PROBE_LIMIT = 8;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    localparam int EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    localparam logic [31:0] HASH_X = 32'd73856093;
    localparam logic [31:0] HASH_Y = 32'd19349663;
    localparam logic [31:0] HASH_Z = 32'd83492791;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_VOXEL_SIZE = 1'b0;
    localparam logic [RES_W-1:0] VOXEL_SIZE_RESET = RES_W'(410);

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [COORD_W-1:0] kx;
        logic [COORD_W-1:0] ky;
        logic [COORD_W-1:0] kz;
    } t_entry;

endpackage

FILE: rtl/core/vgdf_if.sv
// ----------------------------------------------------------------------------
// vgdf point and result channels
// valid/ready channels for input points and filtered results
// ----------------------------------------------------------------------------
interface vgdf_pt_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  px;
    logic signed [23:0]  py;
    logic signed [23:0]  pz;
    logic                cloud_start;

    modport source (output valid, output px, output py, output pz,
                    output cloud_start, input ready);
    modport sink   (input valid, input px, input py, input pz,
                    input cloud_start, output ready);
endinterface

interface vgdf_res_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  out_x;
    logic signed [23:0]  out_y;
    logic signed [23:0]  out_z;
    logic                kept;
    logic                set_overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output kept, output set_overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input kept, input set_overflow, output ready);
endinterface

FILE: rtl/core/voxel_grid_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// voxel_grid_duplicate_filter_top
// keeps the first point of each voxel per cloud using a probed hash set
// ----------------------------------------------------------------------------
//  channel   | dir | handshake      | payload
//  i_pt      | in  | valid / ready  | px, py, pz, cloud_start
//  o_res     | out | valid / ready  | out_x, out_y, out_z, kept, set_overflow
//  apb       | in  | psel / penable | paddr, pwdata, prdata (voxel_size)
//
//  one point at a time, set by the 25-step serial dividers and the read-compare
//  loop over the slot memory
//  a new point is taken while the previous result still waits in o_res
//  after reset a clearing pass over all 4096 slots runs before the first point;
//  every 255th cloud_start triggers the same pass when the epoch tag wraps
//  o_res stalls hold only the result register and the final state
// ----------------------------------------------------------------------------
module voxel_grid_duplicate_filter_top
    import vgdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vgdf_pt_if.sink               i_pt,
    vgdf_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_START = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_HASH  = 9'b000010000,
        ST_MIX   = 9'b000100000,
        ST_RD    = 9'b001000000,
        ST_CMP   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } t_state;

    t_state               n_state;
    t_state               r_state;

    logic [RES_W-1:0]     r_voxel_size;
    logic [EPOCH_W-1:0]   r_epoch;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic                 r_pending;
    logic [ADDR_W-1:0]    r_slot;
    logic [PROBE_W-1:0]   r_probe;

    logic signed [COORD_W-1:0] r_px, r_py, r_pz;
    logic [COORD_W-1:0]   r_kx, r_ky, r_kz;
    logic [31:0]          r_hx, r_hy, r_hz;
    logic                 r_kept, r_ovf;

    logic                 r_out_valid;
    logic signed [COORD_W-1:0] r_out_x, r_out_y, r_out_z;
    logic                 r_out_kept, r_out_ovf;

    t_entry               r_mem [SET_DEPTH];
    t_entry               r_rdata;
    t_entry               w_wdata;
    logic [ADDR_W-1:0]    w_addr;
    logic                 w_we;

    logic                 w_in_xfer, w_out_xfer, w_cfg_wr;
    logic                 w_div_start, w_div_done;
    logic                 w_done_x, w_done_y, w_done_z;
    logic [RES_W-1:0]     w_res;
    logic [COORD_W-1:0]   w_kx, w_ky, w_kz;
    logic                 w_used, w_match, w_out_free;
    logic [31:0]          w_hash;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VOXEL_SIZE);
    assign prdata   = (paddr[2] == REG_VOXEL_SIZE) ? APB_DATA_W'(r_voxel_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel_size <= VOXEL_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_voxel_size <= pwdata[RES_W-1:0];
        end
    end

    // zero voxel size acts as one
    assign w_res = (r_voxel_size == '0) ? RES_W'(1) : r_voxel_size;

    assign w_div_start = (r_state == ST_START);

    vgdf_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_value(r_px), .i_res(w_res), .o_done(w_done_x), .o_key(w_kx)
    );
    vgdf_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_value(r_py), .i_res(w_res), .o_done(w_done_y), .o_key(w_ky)
    );
    vgdf_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_value(r_pz), .i_res(w_res), .o_done(w_done_z), .o_key(w_kz)
    );

    assign w_div_done = w_done_x && w_done_y && w_done_z;

    assign i_pt.ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_pt.valid && i_pt.ready;
    assign w_out_xfer = r_out_valid && o_res.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    // a slot is in use only if its tag matches the current epoch
    assign w_used  = (r_rdata.tag == r_epoch);
    assign w_match = (r_rdata.kx == r_kx) && (r_rdata.ky == r_ky) && (r_rdata.kz == r_kz);
    assign w_hash  = r_hx ^ r_hy ^ r_hz;

    // slot memory: one port, read data registered
    always_comb begin
        w_addr  = (r_state == ST_CLEAR) ? r_clr_addr : r_slot;
        w_we    = (r_state == ST_CLEAR) || ((r_state == ST_CMP) && !w_used);
        w_wdata = '0;
        if (r_state != ST_CLEAR) begin
            w_wdata.tag = r_epoch;
            w_wdata.kx  = r_kx;
            w_wdata.ky  = r_ky;
            w_wdata.kz  = r_kz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == {ADDR_W{1'b1}}) begin
                n_state = r_pending ? ST_START : ST_IDLE;
            end
            ST_IDLE: if (w_in_xfer) begin
                n_state = (i_pt.cloud_start && (r_epoch == EPOCH_LAST)) ? ST_CLEAR : ST_START;
            end
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (w_div_done) n_state = ST_HASH;
            ST_HASH:  n_state = ST_MIX;
            ST_MIX:   n_state = ST_RD;
            ST_RD:    n_state = ST_CMP;
            ST_CMP: begin
                if (!w_used || w_match || (r_probe == PROBE_W'(PROBE_LIMIT - 1))) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    r_epoch   <= EPOCH_FIRST;
                    r_pending <= 1'b0;
                end
            end
            if (w_in_xfer && i_pt.cloud_start) begin
                if (r_epoch == EPOCH_LAST) begin
                    r_pending <= 1'b1;
                end else begin
                    r_epoch <= r_epoch + EPOCH_W'(1);
                end
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_px <= i_pt.px;
            r_py <= i_pt.py;
            r_pz <= i_pt.pz;
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_kx <= w_kx;
            r_ky <= w_ky;
            r_kz <= w_kz;
        end
        if (r_state == ST_HASH) begin
            r_hx <= 32'({8'h0, r_kx} * HASH_X);
            r_hy <= 32'({8'h0, r_ky} * HASH_Y);
            r_hz <= 32'({8'h0, r_kz} * HASH_Z);
        end
        if (r_state == ST_MIX) begin
            r_slot  <= w_hash[ADDR_W-1:0];
            r_probe <= '0;
        end
        if (r_state == ST_CMP) begin
            r_slot  <= r_slot + ADDR_W'(1);
            r_probe <= r_probe + PROBE_W'(1);
            r_kept  <= !w_used || !w_match;
            r_ovf   <= w_used && !w_match;
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_out_x    <= r_px;
            r_out_y    <= r_py;
            r_out_z    <= r_pz;
            r_out_kept <= r_kept;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_x        = r_out_x;
    assign o_res.out_y        = r_out_y;
    assign o_res.out_z        = r_out_z;
    assign o_res.kept         = r_out_kept;
    assign o_res.set_overflow = r_out_ovf;

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_probe < PROBE_W'(PROBE_LIMIT)))
        else $error("probe count past limit");

    a_write_when: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == ST_CLEAR) || (r_state == ST_CMP)))
        else $error("slot memory written outside clear or insert");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch tag matches cleared slots");

    a_ovf_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> r_out_kept)
        else $error("overflow result not kept");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_pt.ready)
        else $error("point taken during clearing pass");

endmodule

FILE: rtl/core/vgdf_div.sv
// ----------------------------------------------------------------------------
// vgdf_div
// bit-serial voxel index: sign(v) * floor((2|v| + res) / (2 res))
// ----------------------------------------------------------------------------
module vgdf_div
    import vgdf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_value,
    input  logic [RES_W-1:0]          i_res,
    output logic                      o_done,
    output logic [COORD_W-1:0]        o_key
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     r_rem;
    logic [COORD_W-1:0]   r_den;
    logic                 r_neg;

    logic [COORD_W-1:0]   w_mag;
    logic [NUM_W-1:0]     w_shift;
    logic                 w_ge;

    assign w_mag   = i_value[COORD_W-1] ? (~i_value + COORD_W'(1)) : i_value;
    assign w_shift = {r_rem[NUM_W-2:0], r_num[NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_mag, 1'b0} + NUM_W'(i_res);
            r_rem <= '0;
            r_den <= {i_res, 1'b0};
            r_neg <= i_value[COORD_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - NUM_W'(r_den)) : w_shift;
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    // quotient never exceeds 2^23, so the low bits carry it exactly
    assign o_key = r_neg ? (~r_num[COORD_W-1:0] + COORD_W'(1)) : r_num[COORD_W-1:0];

endmodule
